>>> design/lps_pkg.sv
// Shared types and constants for the line pixel stepper.
package lps_pkg;

  localparam int COORD_BITS = 16;
  localparam int LEN_W      = COORD_BITS + 1;
  localparam int PIX_W      = 17;
  localparam int COLOR_W    = 24;
  localparam int WIN_W      = 15;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [WIN_W-1:0] WIDTH_RESET  = WIN_W'(1920);
  localparam logic [WIN_W-1:0] HEIGHT_RESET = WIN_W'(1080);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STATUS_IDLE     = 2'd0,
    STATUS_LOADED   = 2'd1,
    STATUS_REJECTED = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [WIN_W-1:0] width;
    logic [WIN_W-1:0] height;
  } window_t;

endpackage

>>> design/line_pixel_stepper.sv
// Top level of the line pixel stepper: line setup, pixel stepping and result register.
// An accepted command's result is written into the output register on the following cycle.
// Throughput: one command per cycle unless stalled; a step command on an active line yields
// one pixel from the quotient and remainder accumulator, updated by add, compare, subtract.
// A command is taken while a result waits, as long as that result is taken in the same cycle.
// Reset clears the active line and the result valid flag and sets the window to 1920 by 1080.
module line_pixel_stepper import lps_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic        [COLOR_W-1:0]    line_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         pixel_valid,
  output logic signed [PIX_W-1:0]      pixel_x,
  output logic signed [PIX_W-1:0]      pixel_y,
  output logic        [COLOR_W-1:0]    pixel_color,
  output logic                         last_pixel,
  output logic        [1:0]            line_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic        [ADDR_W-1:0]     paddr,
  input  logic        [DATA_W-1:0]     pwdata,
  output logic        [DATA_W-1:0]     prdata,
  output logic                         pready
);

  window_t window;

  lps_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  // Line state.
  logic                         line_active, line_active_next;
  logic                         x_major;
  logic                         major_negative;
  logic                         minor_negative;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic        [LEN_W-1:0]      major_offset;
  logic        [LEN_W-1:0]      major_length;
  logic        [LEN_W-1:0]      minor_length;
  logic        [LEN_W-1:0]      minor_quotient;
  logic        [LEN_W-1:0]      minor_remainder;
  logic        [COLOR_W-1:0]    held_color;

  logic accept;
  logic do_load;
  logic do_setup;
  logic do_advance;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Load path: deltas, magnitudes and trivial rejection.
  logic signed [LEN_W-1:0] dx, dy;
  logic        [LEN_W-1:0] ax, ay;
  logic signed [31:0]      sx_w, sy_w, ex_w, ey_w, win_w, win_h;
  logic                    rejected, empty_line, x_major_new;
  status_t                 load_status;

  always_comb begin
    dx    = LEN_W'(end_x) - LEN_W'(start_x);
    dy    = LEN_W'(end_y) - LEN_W'(start_y);
    ax    = dx[LEN_W-1] ? LEN_W'(-dx) : LEN_W'(dx);
    ay    = dy[LEN_W-1] ? LEN_W'(-dy) : LEN_W'(dy);
    sx_w  = 32'(start_x);
    sy_w  = 32'(start_y);
    ex_w  = 32'(end_x);
    ey_w  = 32'(end_y);
    win_w = signed'(32'(window.width));
    win_h = signed'(32'(window.height));
    rejected = (start_x[COORD_BITS-1] & end_x[COORD_BITS-1]) |
               (start_y[COORD_BITS-1] & end_y[COORD_BITS-1]) |
               ((sx_w > win_w) & (ex_w > win_w)) |
               ((sy_w > win_h) & (ey_w > win_h));
    empty_line  = (dx == '0) & (dy == '0);
    x_major_new = ax > ay;
    if (rejected) begin
      load_status = STATUS_REJECTED;
    end else if (empty_line) begin
      load_status = STATUS_EMPTY;
    end else begin
      load_status = STATUS_LOADED;
    end
  end

  // Step path: current pixel and accumulator update.
  logic signed [LEN_W:0] maj_off, mnr_off, px_full, py_full;
  logic        [LEN_W:0] rem_sum, offset_inc;
  logic                  rem_wrap, is_last;

  always_comb begin
    maj_off = major_negative ? -signed'({1'b0, major_offset})
                             :  signed'({1'b0, major_offset});
    mnr_off = minor_negative ? -signed'({1'b0, minor_quotient})
                             :  signed'({1'b0, minor_quotient});
    if (x_major) begin
      px_full = (LEN_W+1)'(origin_x) + maj_off;
      py_full = (LEN_W+1)'(origin_y) + mnr_off;
    end else begin
      px_full = (LEN_W+1)'(origin_x) + mnr_off;
      py_full = (LEN_W+1)'(origin_y) + maj_off;
    end
    offset_inc = {1'b0, major_offset} + (LEN_W+1)'(1);
    is_last    = offset_inc >= {1'b0, major_length};
    // The remainder stays below the major length, so one subtract keeps it in range.
    rem_sum    = {1'b0, minor_remainder} + {1'b0, minor_length};
    rem_wrap   = rem_sum >= {1'b0, major_length};
  end

  assign do_load    = accept & (command_t'(command) == CMD_LOAD);
  assign do_setup   = do_load & ~rejected & ~empty_line;
  assign do_advance = accept & (command_t'(command) == CMD_STEP) & line_active & ~is_last;

  always_comb begin
    line_active_next = line_active;
    if (do_load) begin
      line_active_next = do_setup;
    end else if (accept && line_active && is_last) begin
      line_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else begin
      line_active <= line_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_setup) begin
      x_major         <= x_major_new;
      major_negative  <= x_major_new ? dx[LEN_W-1] : dy[LEN_W-1];
      minor_negative  <= x_major_new ? dy[LEN_W-1] : dx[LEN_W-1];
      major_length    <= x_major_new ? ax : ay;
      minor_length    <= x_major_new ? ay : ax;
      origin_x        <= start_x;
      origin_y        <= start_y;
      major_offset    <= '0;
      minor_quotient  <= '0;
      minor_remainder <= '0;
      held_color      <= line_color;
    end else if (do_advance) begin
      major_offset <= offset_inc[LEN_W-1:0];
      if (rem_wrap) begin
        minor_remainder <= LEN_W'(rem_sum - {1'b0, major_length});
        minor_quotient  <= minor_quotient + LEN_W'(1);
      end else begin
        minor_remainder <= rem_sum[LEN_W-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (command_t'(command) == CMD_LOAD) begin
        pixel_valid <= 1'b0;
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_color <= '0;
        last_pixel  <= 1'b0;
        line_status <= load_status;
      end else if (line_active) begin
        pixel_valid <= 1'b1;
        pixel_x     <= PIX_W'(px_full);
        pixel_y     <= PIX_W'(py_full);
        pixel_color <= held_color;
        last_pixel  <= is_last;
        line_status <= STATUS_LOADED;
      end else begin
        pixel_valid <= 1'b0;
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_color <= '0;
        last_pixel  <= 1'b0;
        line_status <= STATUS_IDLE;
      end
    end
  end

endmodule

>>> design/lps_cfg_regs.sv
// APB-style register file holding the rejection window edges.
module lps_cfg_regs import lps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output window_t           window
);

  logic       write_en;
  reg_index_t reg_sel;

  assign pready   = 1'b1;
  assign write_en = psel & penable & pwrite & pready;
  assign reg_sel  = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window.width  <= WIDTH_RESET;
      window.height <= HEIGHT_RESET;
    end else if (write_en) begin
      case (reg_sel)
        REG_WIDTH:  window.width  <= pwdata[WIN_W-1:0];
        REG_HEIGHT: window.height <= pwdata[WIN_W-1:0];
        default:    window.width  <= window.width;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = DATA_W'(window.width);
      REG_HEIGHT: prdata = DATA_W'(window.height);
      default:    prdata = '0;
    endcase
  end

endmodule
